// ===== design/acrms_pkg.sv =====
// ----------------------------------------------------------------------------
// acrms_pkg: shared constants for the AC RMS voltage and frequency meter
// Field widths, register indexes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package acrms_pkg;

   // parameter defaults
   localparam int ADC_BITS_DEF   = 10;
   localparam int MAX_WINDOW_DEF = 4096;

   // field widths
   localparam int SAMPLE_W  = 10;
   localparam int REQ_W     = 16;
   localparam int VOLT_W    = 14;
   localparam int FREQ_W    = 16;
   localparam int RSP_W     = 32;
   localparam int CNT_W     = 13;
   localparam int SUM_W     = 32;
   localparam int IVL_W     = 16;
   localparam int MID_W     = 10;
   localparam int GAIN_W    = 16;
   localparam int OFS_W     = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // frequency scaling: 0.01 Hz units, two crossings per period
   localparam int NUM_K_W = 26;
   localparam logic [NUM_K_W-1:0] FREQ_NUM = 26'd50000000;

   // shared divider and root unit sizes
   localparam int DVD_W  = CNT_W + NUM_K_W;
   localparam int DVS_W  = CNT_W + IVL_W;
   localparam int ROOT_W = SUM_W / 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_SIZE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MID_POINT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_VOLTAGE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VOLTAGE = 3'd6;

   // register reset values
   localparam logic [CNT_W-1:0]  RST_SAMPLE_SIZE = 13'd100;
   localparam logic [IVL_W-1:0]  RST_INTERVAL    = 16'd1000;
   localparam logic [MID_W-1:0]  RST_MID_POINT   = 10'd512;
   localparam logic [GAIN_W-1:0] RST_SCALE_GAIN  = 16'd256;
   localparam logic [OFS_W-1:0]  RST_OFFSET      = 11'd0;
   localparam logic [VOLT_W-1:0] RST_MIN_VOLTAGE = 14'd0;
   localparam logic [VOLT_W-1:0] RST_MAX_VOLTAGE = 14'd10000;

endpackage

// ===== design/ac_rms_voltage_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// ac_rms_voltage_frequency_meter: true-RMS voltage and line frequency meter
// Accumulates squared, centered converter samples and sign crossings over a
// window, then reports RMS voltage (0.1 V) and frequency (0.01 Hz).
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one converter sample per request (req_tdata[9:0]).
//   rsp_*  : one result per window, voltage in rsp_tdata[13:0] and
//            frequency in rsp_tdata[29:14].
//   csr_*  : register writes (index, data), always ready; write only while
//            the meter is idle.
// Samples: one at a time; a new sample is accepted only once the
//   bit-serial squarer (one multiplier bit per cycle) has finished and its
//   square has been accumulated.
// Window end: after the last sample of a window, the mean square passes the
//   shared 39-step restoring divider and the 16-step root unit, then the frequency
//   takes a second divider pass before the result enters the output register.
// Reset: registers return to defaults, sum and counters clear, the previous
//   sample reads as zero. No clearing pass is needed.
// Stall: a result waits in the output register; samples keep being accepted
//   until the next window end, which holds until that register is free.
// ----------------------------------------------------------------------------
module ac_rms_voltage_frequency_meter #(
   parameter int ADC_BITS   = acrms_pkg::ADC_BITS_DEF,
   parameter int MAX_WINDOW = acrms_pkg::MAX_WINDOW_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [acrms_pkg::REQ_W-1:0]     req_tdata,   // [9:0] adc_sample
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [acrms_pkg::RSP_W-1:0]     rsp_tdata,   // [13:0] voltage_dv,
                                                        // [29:14] freq_centihz
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [acrms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [acrms_pkg::CSR_DAT_W-1:0] csr_data
);

   localparam int UW    = (ADC_BITS > acrms_pkg::MID_W) ? ADC_BITS : acrms_pkg::MID_W;
   localparam int CW    = UW + 1;
   localparam int SQ_W  = 2 * UW;
   localparam int CNT_W = acrms_pkg::CNT_W;
   localparam int SUM_W = acrms_pkg::SUM_W;
   localparam int DVD_W = acrms_pkg::DVD_W;
   localparam int DVS_W = acrms_pkg::DVS_W;
   localparam int RT_W  = acrms_pkg::ROOT_W;
   localparam int SC_W  = RT_W + acrms_pkg::GAIN_W;
   localparam int V_W   = SC_W - 8 + 2;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SQ      = 3'd1;
   localparam logic [2:0] S_DIV1_GO = 3'd2;
   localparam logic [2:0] S_DIV1    = 3'd3;
   localparam logic [2:0] S_SQRT    = 3'd4;
   localparam logic [2:0] S_MUL     = 3'd5;
   localparam logic [2:0] S_DIV2    = 3'd6;
   localparam logic [2:0] S_OUT     = 3'd7;

   // configuration registers
   logic [CNT_W-1:0]                  size_ff;
   logic [acrms_pkg::IVL_W-1:0]       ivl_ff;
   logic [acrms_pkg::MID_W-1:0]       mid_ff;
   logic [acrms_pkg::GAIN_W-1:0]      gain_ff;
   logic signed [acrms_pkg::OFS_W-1:0] ofs_ff;
   logic [acrms_pkg::VOLT_W-1:0]      vmin_ff;
   logic [acrms_pkg::VOLT_W-1:0]      vmax_ff;

   // window state
   logic [2:0]         state_ff, state_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   xing_ff, xing_in;
   logic               prev_neg_ff, prev_neg_in;
   logic               prev_pos_ff, prev_pos_in;
   logic [DVD_W-1:0]   num_ff;
   logic [DVS_W-1:0]   den_ff;
   logic [SC_W-1:0]    scaled_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [acrms_pkg::RSP_W-1:0] rsp_data_ff;

   // datapath nets
   logic [UW-1:0]    code_u;
   logic [UW-1:0]    mid_u;
   logic [CW-1:0]    cen;
   logic [CW-1:0]    cen_neg;
   logic             c_neg;
   logic             c_zero;
   logic [UW-1:0]    mag;
   logic             crossing;
   logic [CNT_W-1:0] limit;
   logic [SUM_W:0]   sum_wide;
   logic             req_fire;
   logic             out_load;

   logic             sq_start, sq_done;
   logic [SQ_W-1:0]  sq_prod;
   logic             div_start, div_done;
   logic [DVD_W-1:0] div_dvd, div_quo;
   logic [DVS_W-1:0] div_dvs;
   logic             rt_start, rt_done;
   logic [RT_W-1:0]  rt_root;

   logic signed [V_W-1:0]        volt_s;
   logic [acrms_pkg::VOLT_W-1:0] volt;
   logic [acrms_pkg::FREQ_W-1:0] freq;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= acrms_pkg::RST_SAMPLE_SIZE;
         ivl_ff  <= acrms_pkg::RST_INTERVAL;
         mid_ff  <= acrms_pkg::RST_MID_POINT;
         gain_ff <= acrms_pkg::RST_SCALE_GAIN;
         ofs_ff  <= acrms_pkg::RST_OFFSET;
         vmin_ff <= acrms_pkg::RST_MIN_VOLTAGE;
         vmax_ff <= acrms_pkg::RST_MAX_VOLTAGE;
      end else if (csr_valid) begin
         case (csr_index)
            acrms_pkg::REG_SAMPLE_SIZE: size_ff <= csr_data[CNT_W-1:0];
            acrms_pkg::REG_INTERVAL:    ivl_ff  <= csr_data;
            acrms_pkg::REG_MID_POINT:   mid_ff  <= csr_data[acrms_pkg::MID_W-1:0];
            acrms_pkg::REG_SCALE_GAIN:  gain_ff <= csr_data;
            acrms_pkg::REG_OFFSET:      ofs_ff  <= csr_data[acrms_pkg::OFS_W-1:0];
            acrms_pkg::REG_MIN_VOLTAGE: vmin_ff <= csr_data[acrms_pkg::VOLT_W-1:0];
            acrms_pkg::REG_MAX_VOLTAGE: vmax_ff <= csr_data[acrms_pkg::VOLT_W-1:0];
            default: ;
         endcase
      end
   end

   // centering, magnitude and crossing detect
   assign code_u   = UW'(req_tdata[ADC_BITS-1:0]);
   assign mid_u    = UW'(mid_ff);
   assign cen      = {1'b0, code_u} - {1'b0, mid_u};
   assign cen_neg  = CW'(0) - cen;
   assign c_neg    = cen[CW-1];
   assign c_zero   = (cen == '0);
   assign mag      = c_neg ? cen_neg[UW-1:0] : cen[UW-1:0];
   assign crossing = (prev_neg_ff && !c_neg) || (prev_pos_ff && (c_neg || c_zero));

   // effective window length
   always_comb begin
      if (size_ff == '0) begin
         limit = CNT_W'(1);
      end else if (size_ff > CNT_W'(MAX_WINDOW)) begin
         limit = CNT_W'(MAX_WINDOW);
      end else begin
         limit = size_ff;
      end
   end

   assign sum_wide   = {1'b0, sum_ff} + (SUM_W+1)'(sq_prod);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // unit starts and the shared divider operand select
   assign sq_start  = req_fire;
   assign div_start = (state_ff == S_DIV1_GO) || (state_ff == S_MUL);
   assign div_dvd   = (state_ff == S_MUL) ? num_ff : DVD_W'(sum_ff);
   assign div_dvs   = (state_ff == S_MUL) ? den_ff : DVS_W'(cnt_ff);
   assign rt_start  = (state_ff == S_DIV1) && div_done;

   // result formatting
   always_comb begin
      volt_s = $signed({2'b00, scaled_ff[SC_W-1:8]}) + V_W'(ofs_ff);
      if (volt_s < $signed(V_W'(vmin_ff))) begin
         volt_s = '0;
      end
      if (volt_s > $signed(V_W'(vmax_ff))) begin
         volt_s = $signed(V_W'(vmax_ff));
      end
      volt = volt_s[acrms_pkg::VOLT_W-1:0];
      if (den_ff == '0) begin
         freq = (xing_ff != '0) ? '1 : '0;
      end else if (div_quo[DVD_W-1:acrms_pkg::FREQ_W] != '0) begin
         freq = '1;
      end else begin
         freq = div_quo[acrms_pkg::FREQ_W-1:0];
      end
   end

   // sequencer and window accumulation
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      xing_in      = xing_ff;
      prev_neg_in  = prev_neg_ff;
      prev_pos_in  = prev_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cnt_in      = cnt_ff + CNT_W'(1);
               xing_in     = crossing ? xing_ff + CNT_W'(1) : xing_ff;
               prev_neg_in = c_neg;
               prev_pos_in = !c_neg && !c_zero;
               state_in    = S_SQ;
            end
         end
         S_SQ: begin
            if (sq_done) begin
               sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
               state_in = (cnt_ff >= limit) ? S_DIV1_GO : S_IDLE;
            end
         end
         S_DIV1_GO: state_in = S_DIV1;
         S_DIV1: begin
            if (div_done) begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (rt_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: state_in = S_DIV2;
         S_DIV2: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               cnt_in       = '0;
               xing_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         xing_ff      <= '0;
         prev_neg_ff  <= 1'b0;
         prev_pos_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         xing_ff      <= xing_in;
         prev_neg_ff  <= prev_neg_in;
         prev_pos_ff  <= prev_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // window-end products, each registered before use
   always_ff @(posedge clock) begin
      if (state_ff == S_DIV1_GO) begin
         num_ff <= DVD_W'(xing_ff) * DVD_W'(acrms_pkg::FREQ_NUM);
         den_ff <= DVS_W'(cnt_ff) * DVS_W'(ivl_ff);
      end
      if (state_ff == S_MUL) begin
         scaled_ff <= SC_W'(rt_root) * SC_W'(gain_ff);
      end
      if (out_load) begin
         rsp_data_ff <= acrms_pkg::RSP_W'({freq, volt});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   acrms_square #(
      .W (UW)
   ) u_square (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (mag),
      .done    (sq_done),
      .product (sq_prod)
   );

   acrms_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   acrms_sqrt #(
      .IN_W (SUM_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (div_quo[SUM_W-1:0]),
      .done     (rt_done),
      .root     (rt_root)
   );

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_WINDOW))
      else $error("sample count exceeds window limit");

   a_xing_bound: assert property (@(posedge clock) disable iff (reset)
      xing_ff <= cnt_ff)
      else $error("more crossings than samples");

   a_mean_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV1 && div_done) |-> (div_quo[DVD_W-1:SUM_W] == '0))
      else $error("mean square wider than root input");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

endmodule

// ===== design/acrms_square.sv =====
// ----------------------------------------------------------------------------
// acrms_square: bit-serial squarer
// Shift-and-add multiply of an operand by itself, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module acrms_square #(
   parameter int W = 10
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   operand,
   output logic           done,
   output logic [2*W-1:0] product
);

   localparam int CW = $clog2(W + 1);

   logic [2*W-1:0] mcand_ff, mcand_in;
   logic [W-1:0]   mplier_ff, mplier_in;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;

   // one partial product per cycle, multiplier consumed LSB first
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = (2*W)'(operand);
         mplier_in = operand;
         prod_in   = '0;
         cnt_in    = CW'(W);
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[2*W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[W-1:1]};
         cnt_in    = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ===== design/acrms_divider.sv =====
// ----------------------------------------------------------------------------
// acrms_divider: restoring divider
// Unsigned division, one quotient bit a cycle; shared by both window divides.
// ----------------------------------------------------------------------------
module acrms_divider #(
   parameter int DVD_W = 39,
   parameter int DVS_W = 29
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CW = $clog2(DVD_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_shift;
   logic             fits;

   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign fits      = rem_shift >= {1'b0, dvs_ff};

   // shift in the next dividend bit, subtract when the divisor fits
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DVS_W'(rem_shift - {1'b0, dvs_ff});
         end else begin
            rem_in = rem_shift[DVS_W-1:0];
         end
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/acrms_sqrt.sv =====
// ----------------------------------------------------------------------------
// acrms_sqrt: digit-serial integer square root
// Floor square root, two radicand bits (one root bit) a cycle.
// ----------------------------------------------------------------------------
module acrms_sqrt #(
   parameter int IN_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IN_W-1:0]   radicand,
   output logic              done,
   output logic [IN_W/2-1:0] root
);

   localparam int RT_W = IN_W / 2;
   localparam int CW   = $clog2(RT_W + 1);

   logic [IN_W-1:0] x_ff, x_in;
   logic [RT_W:0]   rem_ff, rem_in;
   logic [RT_W-1:0] root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [RT_W+2:0] rem_t;
   logic [RT_W+2:0] trial;
   logic            fits;

   assign rem_t = {rem_ff, x_ff[IN_W-1:IN_W-2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign fits  = rem_t >= trial;

   // classic digit-by-digit root: try 4*root + 1 against the partial remainder
   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(RT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[IN_W-3:0], 2'b00};
         if (fits) begin
            rem_in = (RT_W+1)'(rem_t - trial);
         end else begin
            rem_in = rem_t[RT_W:0];
         end
         root_in = {root_ff[RT_W-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
